// ===== rtl/nmhf_pkg.sv =====
// shared constants and types of the neighbour mean hole fill block
package nmhf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_PASSES = 8;

  // one ring of two rows plus three pixels per pass
  localparam int RING_LEN  = 2 * MAX_WIDTH + 3;
  localparam int MEM_DEPTH = MAX_PASSES * RING_LEN;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int RW        = $clog2(RING_LEN);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int PW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW        = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  // per-channel lane control from the sequencer
  typedef struct packed {
    logic clear;
    logic acc;
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

// ===== rtl/nmhf_lane.sv =====
// one channel lane: neighbour sum and shift-subtract rounding divide
module nmhf_lane (
  input  logic                 clk,
  input  nmhf_pkg::lane_ctl_t  ctl,
  input  logic [7:0]           pix,
  input  logic [3:0]           cnt,
  output logic [7:0]           quot
);

  logic [10:0] sum;
  logic [11:0] q;
  logic [4:0]  rem;
  logic [5:0]  r2;
  logic [4:0]  den;

  assign den = {cnt, 1'b0};
  assign r2  = {rem, q[11]};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
    end else if (ctl.acc) begin
      sum <= sum + {3'b000, pix};
    end
    if (ctl.load) begin
      // numerator 2*sum + cnt gives round half up
      q   <= {sum, 1'b0} + {8'h00, cnt};
      rem <= '0;
    end else if (ctl.step) begin
      if (r2 >= {1'b0, den}) begin
        rem <= 5'(r2 - {1'b0, den});
        q   <= {q[10:0], 1'b1};
      end else begin
        rem <= r2[4:0];
        q   <= {q[10:0], 1'b0};
      end
    end
  end

  assign quot = (q > 12'd255) ? 8'hFF : q[7:0];

endmodule

// ===== rtl/nmhf_merge.sv =====
// merges the lane means into one pixel, keeping nonblank centres
module nmhf_merge (
  input  logic [31:0]       centre,
  input  logic [3:0][7:0]   quot,
  input  logic [3:0]        cnt,
  input  logic [2:0]        ch,
  output logic [31:0]       pix
);

  logic [31:0] filled;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      filled[8*i +: 8] = (3'(i) < ch) ? quot[i] : 8'h00;
    end
    if (centre != 32'h0) begin
      pix = centre;
    end else if (cnt == 4'd0) begin
      pix = 32'h0;
    end else begin
      pix = filled;
    end
  end

endmodule

// ===== rtl/neighbour_mean_hole_fill.sv =====
// top level: pass sequencer, shared line memory, channel lanes and output register
// Hole filling over a 3x3 neighbourhood, pass_count passes in cascade. Items are taken
// one at a time: a new item is accepted only once every pass is done with the last one.
// While the result register still holds an unaccepted result, the last pass waits in its
// final step. The time per item is set by the single read port of the shared line memory
// (nine reads per pass) and the 12-step shift-subtract divider in each of the four channel
// lanes, which run side by side. The line memory needs no clearing after reset; a register
// write restarts the frame.
module neighbour_mean_hole_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // chan_a, chan_b, chan_c, chan_d
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_a, out_b, out_c, out_d
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCHK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RLAST = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [1:0] R_WIDTH  = 2'd0;
  localparam logic [1:0] R_HEIGHT = 2'd1;
  localparam logic [1:0] R_CHAN   = 2'd2;
  localparam logic [1:0] R_PASS   = 2'd3;

  localparam logic [1:0] D_MINUS = 2'd0;
  localparam logic [1:0] D_ZERO  = 2'd1;
  localparam logic [1:0] D_PLUS  = 2'd2;

  // configuration
  logic [10:0] frame_width, frame_height;
  logic [2:0]  channel_count;
  logic [3:0]  pass_count;
  logic        cfg_wr;
  logic [10:0] w, h, wm1, hm1;
  logic [2:0]  ch;
  logic [3:0]  p;
  logic [nmhf_pkg::SW-1:0] pl;
  logic [nmhf_pkg::PW-1:0] n;

  // sequencer
  logic [2:0]  state;
  logic        op;
  logic [31:0] in_pix;
  logic [nmhf_pkg::SW-1:0] s;
  logic [3:0]  j;
  logic [3:0]  dcnt;
  logic [3:0]  cnt;
  logic [31:0] centre;

  // frame progress
  logic [nmhf_pkg::PW-1:0] pending;
  logic [nmhf_pkg::RW-1:0] pend_mod;
  logic [nmhf_pkg::PW-1:0] pos  [nmhf_pkg::MAX_PASSES];
  logic [nmhf_pkg::RW-1:0] smod [nmhf_pkg::MAX_PASSES];
  logic [nmhf_pkg::CW-1:0] sx   [nmhf_pkg::MAX_PASSES];
  logic [nmhf_pkg::CW-1:0] sy   [nmhf_pkg::MAX_PASSES];

  // line memory
  logic [31:0] mem [nmhf_pkg::MEM_DEPTH];
  logic        we;
  logic [nmhf_pkg::AW-1:0] wa, ra;
  logic [31:0] wd, rd_data;
  logic        rd_live, rd_ok, rd_ctr;

  // stage view
  logic [nmhf_pkg::PW-1:0] done, got;
  logic [nmhf_pkg::RW-1:0] cur_mod;
  logic [nmhf_pkg::CW-1:0] cur_x, cur_y;
  logic        emit_ok;
  logic [1:0]  dxc, dyc;
  logic        nb_ok;
  logic signed [nmhf_pkg::RW+1:0] off, t;
  logic [nmhf_pkg::RW-1:0] ring_ix;
  logic        restart;

  // lanes
  nmhf_pkg::lane_ctl_t lctl;
  logic [3:0][7:0] quot;
  logic [31:0] fill_pix;
  logic        out_load;
  logic        acc_hit;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      R_WIDTH:  prdata = {21'h0, frame_width};
      R_HEIGHT: prdata = {21'h0, frame_height};
      R_CHAN:   prdata = {29'h0, channel_count};
      R_PASS:   prdata = {28'h0, pass_count};
      default:  prdata = 32'h0;
    endcase
  end

  assign w   = (frame_width == 11'd0) ? 11'd1 :
               (frame_width > 11'(nmhf_pkg::MAX_WIDTH)) ? 11'(nmhf_pkg::MAX_WIDTH) :
               frame_width;
  assign h   = (frame_height == 11'd0) ? 11'd1 :
               (frame_height > 11'(nmhf_pkg::MAX_HEIGHT)) ? 11'(nmhf_pkg::MAX_HEIGHT) :
               frame_height;
  assign ch  = (channel_count == 3'd0) ? 3'd1 : (channel_count > 3'd4) ? 3'd4 : channel_count;
  assign p   = (pass_count == 4'd0) ? 4'd1 :
               (pass_count > 4'(nmhf_pkg::MAX_PASSES)) ? 4'(nmhf_pkg::MAX_PASSES) : pass_count;
  assign pl  = nmhf_pkg::SW'(p - 4'd1);
  assign wm1 = w - 11'd1;
  assign hm1 = h - 11'd1;

  assign s_tready = (state == S_IDLE);

  assign done    = pos[s];
  assign got     = (s == '0) ? pending : pos[nmhf_pkg::SW'(s - 1'b1)];
  assign cur_mod = smod[s];
  assign cur_x   = sx[s];
  assign cur_y   = sy[s];
  assign emit_ok = (done < n) &&
                   (({1'b0, got} > ({1'b0, done} + (nmhf_pkg::PW+1)'(w) + 1'b1)) || (got == n));
  assign restart = (pending >= n);

  // neighbour offsets in raster order of the window
  always_comb begin
    case (j)
      4'd0, 4'd1, 4'd2: dyc = D_MINUS;
      4'd3, 4'd4, 4'd5: dyc = D_ZERO;
      default:          dyc = D_PLUS;
    endcase
    case (j)
      4'd0, 4'd3, 4'd6: dxc = D_MINUS;
      4'd1, 4'd4, 4'd7: dxc = D_ZERO;
      default:          dxc = D_PLUS;
    endcase
  end

  always_comb begin
    nb_ok = 1'b1;
    off   = '0;
    if (dxc == D_MINUS) begin
      nb_ok = nb_ok && (cur_x != '0);
      off   = off - 2'sd1;
    end else if (dxc == D_PLUS) begin
      nb_ok = nb_ok && ({1'b0, cur_x} != wm1);
      off   = off + 2'sd1;
    end
    if (dyc == D_MINUS) begin
      nb_ok = nb_ok && (cur_y != '0);
      off   = off - $signed({3'b000, w});
    end else if (dyc == D_PLUS) begin
      nb_ok = nb_ok && ({1'b0, cur_y} != hm1);
      off   = off + $signed({3'b000, w});
    end
    t = $signed({2'b00, cur_mod}) + off;
    if (t < 0) begin
      t = t + (nmhf_pkg::RW+2)'(nmhf_pkg::RING_LEN);
    end else if (t >= (nmhf_pkg::RW+2)'(nmhf_pkg::RING_LEN)) begin
      t = t - (nmhf_pkg::RW+2)'(nmhf_pkg::RING_LEN);
    end
    ring_ix = t[nmhf_pkg::RW-1:0];
  end

  assign ra = nmhf_pkg::AW'(s) * nmhf_pkg::AW'(nmhf_pkg::RING_LEN) + nmhf_pkg::AW'(ring_ix);

  // memory write: input pixel into pass 0, or a pass result into the next pass
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = fill_pix;
    if (state == S_START && !op) begin
      we = 1'b1;
      wa = restart ? '0 : nmhf_pkg::AW'(pend_mod);
      wd = in_pix;
    end else if (state == S_FIN && s != pl) begin
      we = 1'b1;
      wa = nmhf_pkg::AW'(nmhf_pkg::SW'(s + 1'b1)) * nmhf_pkg::AW'(nmhf_pkg::RING_LEN)
           + nmhf_pkg::AW'(cur_mod);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  assign acc_hit    = rd_live && !rd_ctr && rd_ok && (rd_data != 32'h0);
  assign lctl.clear = (state == S_SCHK);
  assign lctl.acc   = acc_hit;
  assign lctl.load  = (state == S_DIV) && (dcnt == 4'd0);
  assign lctl.step  = (state == S_DIV) && (dcnt != 4'd0);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    nmhf_lane u_lane (
      .clk  (clk),
      .ctl  (lctl),
      .pix  (rd_data[8*g +: 8]),
      .cnt  (cnt),
      .quot (quot[g])
    );
  end

  nmhf_merge u_merge (
    .centre (centre),
    .quot   (quot),
    .cnt    (cnt),
    .ch     (ch),
    .pix    (fill_pix)
  );

  assign out_load = (state == S_FIN) && (s == pl) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    n <= nmhf_pkg::PW'(w) * nmhf_pkg::PW'(h);
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= 11'd1024;
      frame_height  <= 11'd1024;
      channel_count <= 3'd4;
      pass_count    <= 4'd1;
      pending       <= '0;
      pend_mod      <= '0;
      m_tvalid      <= 1'b0;
      rd_live       <= 1'b0;
      cnt           <= '0;
      s             <= '0;
      for (int i = 0; i < nmhf_pkg::MAX_PASSES; i++) begin
        pos[i]  <= '0;
        smod[i] <= '0;
        sx[i]   <= '0;
        sy[i]   <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_live <= (state == S_READ);
      if (rd_live) begin
        if (rd_ctr) begin
          centre <= rd_data;
        end else if (acc_hit) begin
          cnt <= cnt + 4'd1;
        end
      end

      if (cfg_wr) begin
        case (paddr[3:2])
          R_WIDTH:  frame_width   <= pwdata[10:0];
          R_HEIGHT: frame_height  <= pwdata[10:0];
          R_CHAN:   channel_count <= pwdata[2:0];
          R_PASS:   pass_count    <= pwdata[3:0];
          default:  frame_width   <= frame_width;
        endcase
        pending  <= '0;
        pend_mod <= '0;
        for (int i = 0; i < nmhf_pkg::MAX_PASSES; i++) begin
          pos[i]  <= '0;
          smod[i] <= '0;
          sx[i]   <= '0;
          sy[i]   <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            in_pix <= {(ch > 3'd3) ? s_tdata[31:24] : 8'h00,
                       (ch > 3'd2) ? s_tdata[23:16] : 8'h00,
                       (ch > 3'd1) ? s_tdata[15:8]  : 8'h00,
                       s_tdata[7:0]};
            state  <= S_START;
          end
        end
        S_START: begin
          s <= '0;
          if (op) begin
            if (pending != n || pos[pl] >= n) begin
              state <= S_IDLE;
            end else begin
              state <= S_SCHK;
            end
          end else begin
            if (restart) begin
              pending  <= nmhf_pkg::PW'(1);
              pend_mod <= nmhf_pkg::RW'(1);
              for (int i = 0; i < nmhf_pkg::MAX_PASSES; i++) begin
                pos[i]  <= '0;
                smod[i] <= '0;
                sx[i]   <= '0;
                sy[i]   <= '0;
              end
            end else begin
              pending  <= pending + 1'b1;
              pend_mod <= (pend_mod == nmhf_pkg::RW'(nmhf_pkg::RING_LEN - 1)) ? '0
                          : pend_mod + 1'b1;
            end
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          j   <= '0;
          cnt <= '0;
          if (emit_ok) begin
            state <= S_READ;
          end else if (s == pl) begin
            state <= S_IDLE;
          end else begin
            s <= s + 1'b1;
          end
        end
        S_READ: begin
          rd_ok   <= nb_ok;
          rd_ctr  <= (dxc == D_ZERO) && (dyc == D_ZERO);
          j       <= j + 4'd1;
          if (j == 4'd8) begin
            state <= S_RLAST;
          end
        end
        S_RLAST: begin
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd12) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (s != pl || out_load) begin
            pos[s]  <= done + 1'b1;
            smod[s] <= (cur_mod == nmhf_pkg::RW'(nmhf_pkg::RING_LEN - 1)) ? '0
                       : cur_mod + 1'b1;
            if ({1'b0, cur_x} == wm1) begin
              sx[s] <= '0;
              sy[s] <= cur_y + 1'b1;
            end else begin
              sx[s] <= cur_x + 1'b1;
            end
            if (s == pl) begin
              m_tdata  <= fill_pix;
              m_tlast  <= (done == n - 1'b1);
              state    <= S_IDLE;
            end else begin
              s     <= s + 1'b1;
              state <= S_SCHK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 4'd8 || state == S_SCHK)
    else $error("neighbour count beyond eight");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHK) |-> (done <= n && pending <= n))
    else $error("pass position beyond frame");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && $past(state) == S_FIN))
    else $error("result loaded outside final step");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the neighbour mean hole fill block with its own fill predictor
module tb_top;

  localparam bit OP_PIXEL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;

  localparam int REG_FRAME_WIDTH   = 0;
  localparam int REG_FRAME_HEIGHT  = 1;
  localparam int REG_CHANNEL_COUNT = 2;
  localparam int REG_PASS_COUNT    = 3;

  localparam int SETTLE_CYCLES = 2 + 25 * nmhf_pkg::MAX_PASSES + 50;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int ITEM_TARGET   = 650;

  typedef struct {
    bit [31:0] px;
    bit        last;
  } filled_px_t;

  class fill_scoreboard;
    bit [31:0]   ring [nmhf_pkg::MAX_PASSES][nmhf_pkg::RING_LEN];
    int unsigned stage_done [nmhf_pkg::MAX_PASSES];
    int unsigned pix_in;
    int unsigned cfg [4];
    filled_px_t  filled_q [$];
    int          errors;

    function new();
      cfg = '{1024, 1024, 4, 1};
      errors = 0;
      restart();
    endfunction

    function void restart();
      pix_in = 0;
      foreach (stage_done[i]) stage_done[i] = 0;
    endfunction

    function int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(int idx, bit [31:0] val);
      case (idx)
        REG_FRAME_WIDTH:   cfg[idx] = val & 32'h7ff;
        REG_FRAME_HEIGHT:  cfg[idx] = val & 32'h7ff;
        REG_CHANNEL_COUNT: cfg[idx] = val & 32'h7;
        REG_PASS_COUNT:    cfg[idx] = val & 32'hf;
        default: return;
      endcase
      restart();
    endfunction

    // mean of the nonblank neighbours, from the image of the previous pass
    function bit [31:0] fill_mean(int s, int unsigned k, int unsigned w, int unsigned h,
                                  int unsigned ch);
      bit [31:0]   centre, v, res;
      int unsigned sum [4];
      int unsigned cnt, m;
      int          x, y, nx, ny;
      centre = ring[s][k % nmhf_pkg::RING_LEN];
      if (centre != 0) return centre;
      sum = '{0, 0, 0, 0};
      cnt = 0;
      res = 0;
      x = k % w;
      y = k / w;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx = x + dx;
          ny = y + dy;
          if (dx == 0 && dy == 0) continue;
          if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
          v = ring[s][(ny * w + nx) % nmhf_pkg::RING_LEN];
          if (v == 0) continue;
          for (int c = 0; c < 4; c++) sum[c] += v[8*c +: 8];
          cnt++;
        end
      end
      if (cnt == 0) return 0;
      for (int c = 0; c < int'(ch); c++) begin
        m = (2 * sum[c] + cnt) / (2 * cnt);
        if (m > 255) m = 255;
        res[8*c +: 8] = m[7:0];
      end
      return res;
    endfunction

    function void note_input(bit op, bit [31:0] data);
      int unsigned w, h, ch, p, n, done, got;
      bit [31:0]   px, v;
      filled_px_t  item;
      w  = clampv(cfg[REG_FRAME_WIDTH], 1, nmhf_pkg::MAX_WIDTH);
      h  = clampv(cfg[REG_FRAME_HEIGHT], 1, nmhf_pkg::MAX_HEIGHT);
      ch = clampv(cfg[REG_CHANNEL_COUNT], 1, 4);
      p  = clampv(cfg[REG_PASS_COUNT], 1, nmhf_pkg::MAX_PASSES);
      n  = w * h;
      if (op == OP_FLUSH) begin
        if (pix_in != n || stage_done[p-1] >= n) return;
      end else begin
        if (pix_in >= n) restart();
        px = 0;
        for (int c = 0; c < int'(ch); c++) px[8*c +: 8] = data[8*c +: 8];
        ring[0][pix_in % nmhf_pkg::RING_LEN] = px;
        pix_in++;
      end
      for (int s = 0; s < int'(p); s++) begin
        done = stage_done[s];
        got  = (s == 0) ? pix_in : stage_done[s-1];
        if (done >= n) continue;
        if (!(got > done + w + 1 || got == n)) continue;
        v = fill_mean(s, done, w, h, ch);
        stage_done[s] = done + 1;
        if (s + 1 < int'(p)) begin
          ring[s+1][done % nmhf_pkg::RING_LEN] = v;
        end else begin
          item.px   = v;
          item.last = (done == n - 1);
          filled_q.insert(filled_q.size(), item);
        end
      end
    endfunction

    function void check_result(bit [31:0] px, bit last);
      filled_px_t want;
      if (filled_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %h last %b", px, last);
        return;
      end
      want = filled_q.pop_front();
      if (want.px !== px || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected %h last %b, got %h last %b",
                   want.px, want.last, px, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fill_scoreboard sb = new();
  int          cycles = 0;
  int          items_sent = 0;
  bit          no_gaps = 1'b0;

  always #1 clk = ~clk;

  neighbour_mean_hole_fill i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, with stall-free stretches now and then
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) no_gaps = ~no_gaps;
      if (stall > 0) begin
        stall--;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
        if (!no_gaps) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // drives one transaction; valid stays high into the next call when no gap is chosen
  task automatic send_item(bit op, bit [31:0] data);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, data);
    items_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.filled_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(int idx, bit [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = 4'(4 * idx);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_frame(bit [31:0] w, bit [31:0] h, bit [31:0] ch, bit [31:0] p);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    apb_write(REG_CHANNEL_COUNT, ch);
    apb_write(REG_PASS_COUNT, p);
  endtask

  function automatic bit [31:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'h0;
    if (r < 55) return {6'd0, 2'($urandom), 6'd0, 2'($urandom),
                        6'd0, 2'($urandom), 6'd0, 2'($urandom)};
    return $urandom;
  endfunction

  // whole frame then flushes, enough to drain it when full_drain is set, with some noise
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned p, bit full_drain);
    int unsigned flushes;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_FLUSH, $urandom);
      send_item(OP_PIXEL, rand_pixel());
    end
    flushes = p * (w + 1) + $urandom_range(0, 2);
    if (!full_drain) flushes = $urandom_range(0, flushes);
    repeat (flushes) send_item(OP_FLUSH, $urandom);
  endtask

  initial begin
    int unsigned w, h, ch, p;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // painted to zero: three faint neighbours round to blank, then a second pass
    set_frame(3, 3, 4, 2);
    send_item(OP_FLUSH, 32'h0);  // flush before the frame is complete
    send_item(OP_PIXEL, 32'h0000_0001);
    send_item(OP_PIXEL, 32'h0000_0100);
    send_item(OP_PIXEL, 32'h0001_0000);
    repeat (6) send_item(OP_PIXEL, 32'h0);
    repeat (9) send_item(OP_FLUSH, 32'hffff_ffff);  // last ones find the frame drained
    // channel extremes and zero channels, frame abandoned by a new one
    send_item(OP_PIXEL, 32'hffff_ffff);
    send_item(OP_PIXEL, 32'h0);
    send_item(OP_PIXEL, 32'hff00_ff00);
    send_item(OP_PIXEL, 32'h0);
    go_idle();
    set_frame(0, 0, 0, 0);  // clamped to the smallest frame
    send_item(OP_PIXEL, 32'h0);
    send_item(OP_PIXEL, 32'h1234_5678);
    send_item(OP_FLUSH, 32'h0);
    go_idle();
    set_frame(2, 2, 7, 15);
    send_item(OP_PIXEL, 32'hffff_ffff);
    repeat (3) send_item(OP_PIXEL, 32'h0);
    repeat (30) send_item(OP_FLUSH, 32'h0);
    go_idle();

    while (items_sent < ITEM_TARGET) begin
      w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
      h  = $urandom_range(0, 6);
      ch = $urandom_range(0, 7);
      p  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      set_frame(w, h, ch, p);
      w = sb.clampv(w, 1, nmhf_pkg::MAX_WIDTH);
      h = sb.clampv(h, 1, nmhf_pkg::MAX_HEIGHT);
      p = sb.clampv(p, 1, nmhf_pkg::MAX_PASSES);
      repeat ($urandom_range(1, 3)) run_frame(w, h, p, $urandom_range(0, 7) != 0);
      go_idle();
    end

    go_idle();
    if (sb.errors == 0 && sb.filled_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
